### rtl/core/quaternion_vector_rotation_top_assert.svh
// Assertion macros used by the quaternion vector rotation top level.
`ifndef QUATERNION_VECTOR_ROTATION_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/qvr_pkg.sv
// Types, widths and register codes of the quaternion vector rotation block.
`default_nettype none

package qvr_pkg;

    // Field widths.
    localparam int QUAT_BITS   = 18;
    localparam int VEC_BITS    = 32;
    localparam int HALF_BITS   = 16;
    localparam int PROD_BITS   = 36;
    localparam int COEF_BITS   = 38;

    // Datapath widths of one matrix row.
    localparam int HI_BITS     = 54;
    localparam int LO_BITS     = 55;
    localparam int HI_SUM_BITS = 56;
    localparam int LO_SUM_BITS = 57;
    localparam int T_BITS      = 58;
    localparam int R_BITS      = T_BITS - HALF_BITS;

    // Pipeline shape: input stage, products, sums, rounding, output.
    localparam int NUM_STAGES    = 5;
    localparam int SETTLE_CYCLES = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_W = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_X = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_Z = 2'd3;

    typedef logic signed [QUAT_BITS-1:0] quat_t;
    typedef logic signed [VEC_BITS-1:0]  vec_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [2:0]                 coef_row_t;
    typedef coef_row_t [2:0]             coef_mat_t;
    typedef vec_t [2:0]                  vec3_t;

    // Reset values of the quaternion: the identity rotation.
    localparam quat_t QUAT_W_RESET = 18'sd65536;
    localparam quat_t QUAT_V_RESET = 18'sd0;

    // Stage load strobes handed from the pipeline control to the rows.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } qvr_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/qvr_coef.sv
// Two-stage rotation matrix builder fed by the quaternion registers.
`default_nettype none

module qvr_coef (
    input  wire logic              aclk,
    input  wire qvr_pkg::quat_t    quat_w_i,
    input  wire qvr_pkg::quat_t    quat_x_i,
    input  wire qvr_pkg::quat_t    quat_y_i,
    input  wire qvr_pkg::quat_t    quat_z_i,
    output qvr_pkg::coef_mat_t     coef_o
);
    import qvr_pkg::*;

    typedef logic signed [PROD_BITS-1:0] prod_t;

    prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    prod_t ww_next, xx_next, yy_next, zz_next, xy_next, wz_next, xz_next, wy_next;
    prod_t yz_next, wx_next;
    coef_mat_t coef_reg, coef_next;

    // All pairwise products of the quaternion components.
    always_comb begin
        ww_next = prod_t'(quat_w_i) * prod_t'(quat_w_i);
        xx_next = prod_t'(quat_x_i) * prod_t'(quat_x_i);
        yy_next = prod_t'(quat_y_i) * prod_t'(quat_y_i);
        zz_next = prod_t'(quat_z_i) * prod_t'(quat_z_i);
        xy_next = prod_t'(quat_x_i) * prod_t'(quat_y_i);
        wz_next = prod_t'(quat_w_i) * prod_t'(quat_z_i);
        xz_next = prod_t'(quat_x_i) * prod_t'(quat_z_i);
        wy_next = prod_t'(quat_w_i) * prod_t'(quat_y_i);
        yz_next = prod_t'(quat_y_i) * prod_t'(quat_z_i);
        wx_next = prod_t'(quat_w_i) * prod_t'(quat_x_i);
    end

    always_ff @(posedge aclk) begin
        ww_reg <= ww_next;
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        zz_reg <= zz_next;
        xy_reg <= xy_next;
        wz_reg <= wz_next;
        xz_reg <= xz_next;
        wy_reg <= wy_next;
        yz_reg <= yz_next;
        wx_reg <= wx_next;
    end

    // Matrix form of q * (0, v) * conj(q), unnormalized.
    always_comb begin
        coef_next[0][0] = coef_t'(ww_reg) + coef_t'(xx_reg) - coef_t'(yy_reg)
                        - coef_t'(zz_reg);
        coef_next[0][1] = (coef_t'(xy_reg) - coef_t'(wz_reg)) <<< 1;
        coef_next[0][2] = (coef_t'(xz_reg) + coef_t'(wy_reg)) <<< 1;
        coef_next[1][0] = (coef_t'(xy_reg) + coef_t'(wz_reg)) <<< 1;
        coef_next[1][1] = coef_t'(ww_reg) - coef_t'(xx_reg) + coef_t'(yy_reg)
                        - coef_t'(zz_reg);
        coef_next[1][2] = (coef_t'(yz_reg) - coef_t'(wx_reg)) <<< 1;
        coef_next[2][0] = (coef_t'(xz_reg) - coef_t'(wy_reg)) <<< 1;
        coef_next[2][1] = (coef_t'(yz_reg) + coef_t'(wx_reg)) <<< 1;
        coef_next[2][2] = coef_t'(ww_reg) - coef_t'(xx_reg) - coef_t'(yy_reg)
                        + coef_t'(zz_reg);
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    assign coef_o = coef_reg;

endmodule

`default_nettype wire

### rtl/core/qvr_row.sv
// Pipelined dot product of one matrix row with the vector, rounded and saturated.
`default_nettype none

module qvr_row (
    input  wire logic                aclk,
    input  wire qvr_pkg::qvr_ctrl_t  ctrl_i,
    input  wire qvr_pkg::vec3_t      vec_i,
    input  wire qvr_pkg::coef_row_t  coef_i,
    output qvr_pkg::vec_t            rot_o
);
    import qvr_pkg::*;

    typedef logic signed [HI_BITS-1:0]     hi_t;
    typedef logic signed [LO_BITS-1:0]     lo_t;
    typedef logic signed [HI_SUM_BITS-1:0] hi_sum_t;
    typedef logic signed [LO_SUM_BITS-1:0] lo_sum_t;
    typedef logic signed [T_BITS-1:0]      t_t;
    typedef logic signed [R_BITS-1:0]      r_t;

    localparam t_t ROUND_HALF = t_t'(1) <<< (HALF_BITS - 1);

    hi_t     hi_reg [3];
    hi_t     hi_next [3];
    lo_t     lo_reg [3];
    lo_t     lo_next [3];
    hi_sum_t hi_sum_reg, hi_sum_next;
    lo_sum_t lo_sum_reg, lo_sum_next;
    t_t      t_reg, t_next;
    r_t      r_val;
    vec_t    rot_reg, rot_next;

    // Stage 1: each coefficient times the signed upper and unsigned lower half.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            hi_next[j] = hi_t'($signed(coef_i[j]))
                       * hi_t'($signed(vec_i[j][VEC_BITS-1:HALF_BITS]));
            lo_next[j] = lo_t'($signed(coef_i[j]))
                       * lo_t'({1'b0, vec_i[j][HALF_BITS-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load[1]) begin
            for (int j = 0; j < 3; j++) begin
                hi_reg[j] <= hi_next[j];
                lo_reg[j] <= lo_next[j];
            end
        end
    end

    // Stage 2: sum the three upper and the three lower partial products.
    always_comb begin
        hi_sum_next = hi_sum_t'(hi_reg[0]) + hi_sum_t'(hi_reg[1]) + hi_sum_t'(hi_reg[2]);
        lo_sum_next = lo_sum_t'(lo_reg[0]) + lo_sum_t'(lo_reg[1]) + lo_sum_t'(lo_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load[2]) begin
            hi_sum_reg <= hi_sum_next;
            lo_sum_reg <= lo_sum_next;
        end
    end

    // Stage 3: merge the halves and add one half LSB for rounding.
    always_comb begin
        t_next = t_t'(hi_sum_reg) + t_t'(lo_sum_reg >>> HALF_BITS) + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load[3]) begin
            t_reg <= t_next;
        end
    end

    // Stage 4: drop the fraction (floor) and clamp to the 32-bit range.
    always_comb begin
        r_val = t_reg[T_BITS-1:HALF_BITS];
        if (r_val[R_BITS-1:VEC_BITS-1] == '0 || r_val[R_BITS-1:VEC_BITS-1] == '1) begin
            rot_next = r_val[VEC_BITS-1:0];
        end else if (r_val[R_BITS-1]) begin
            rot_next = {1'b1, {(VEC_BITS-1){1'b0}}};
        end else begin
            rot_next = {1'b0, {(VEC_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load[4]) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_o = rot_reg;

endmodule

`default_nettype wire

### rtl/core/quaternion_vector_rotation_top.sv
// Top level of the quaternion vector rotation pipeline.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_vec_x, s_vec_y, s_vec_z
//  m_        out        m_valid / m_ready      m_rot_x, m_rot_y, m_rot_z
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One vector per cycle is accepted when settled and the output is not stalled;
// m_valid rises once the transfer has passed through every stage register.
// The depth is set by the input, per-row multiply, sum, rounding and output stages.
// After reset and after each configuration write, s_ready stays low
// while the two-stage matrix builder settles.
// A stalled output holds full stages with no bubble after them; others advance and fill.
`default_nettype none
`include "quaternion_vector_rotation_top_assert.svh"

module quaternion_vector_rotation_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire qvr_pkg::vec_t                     s_vec_x,
    input  wire qvr_pkg::vec_t                     s_vec_y,
    input  wire qvr_pkg::vec_t                     s_vec_z,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output qvr_pkg::vec_t                          m_rot_x,
    output qvr_pkg::vec_t                          m_rot_y,
    output qvr_pkg::vec_t                          m_rot_z,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [qvr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire qvr_pkg::quat_t                    cfg_data
);
    import qvr_pkg::*;

    localparam int SETTLE_W = $clog2(SETTLE_CYCLES + 1);

    quat_t quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic [SETTLE_W-1:0]   settle_reg, settle_next;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic                  cfg_wr;
    logic                  settled;
    vec3_t                 vec_reg;
    coef_mat_t             coef;
    qvr_ctrl_t             ctrl;
    vec_t                  rot [3];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Quaternion registers, written by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg <= QUAT_W_RESET;
            quat_x_reg <= QUAT_V_RESET;
            quat_y_reg <= QUAT_V_RESET;
            quat_z_reg <= QUAT_V_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_QUAT_W: quat_w_reg <= cfg_data;
                REG_QUAT_X: quat_x_reg <= cfg_data;
                REG_QUAT_Y: quat_y_reg <= cfg_data;
                REG_QUAT_Z: quat_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold off input transfers until the matrix reflects the registers.
    always_comb begin
        if (cfg_wr) begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - 1'b1;
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign settled = (settle_reg == '0);

    // A stage can load when it is empty or its successor can load.
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_ready   = stage_ready[0] && settled;
    assign ctrl.load = stage_ready;

    // Valid bits travel with the data.
    always_comb begin
        valid_next = valid_reg;
        if (stage_ready[0]) begin
            valid_next[0] = s_valid && settled;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Input stage register.
    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            vec_reg[0] <= s_vec_x;
            vec_reg[1] <= s_vec_y;
            vec_reg[2] <= s_vec_z;
        end
    end

    qvr_coef u_coef (
        .aclk     (aclk),
        .quat_w_i (quat_w_reg),
        .quat_x_i (quat_x_reg),
        .quat_y_i (quat_y_reg),
        .quat_z_i (quat_z_reg),
        .coef_o   (coef)
    );

    // One dot-product pipeline per output component.
    for (genvar i = 0; i < 3; i++) begin : g_row
        qvr_row u_row (
            .aclk   (aclk),
            .ctrl_i (ctrl),
            .vec_i  (vec_reg),
            .coef_i (coef[i]),
            .rot_o  (rot[i])
        );
    end

    assign m_valid = valid_reg[NUM_STAGES-1];
    assign m_rot_x = rot[0];
    assign m_rot_y = rot[1];
    assign m_rot_z = rot[2];

    // Checks on the pipeline control.
    `QVR_ASSERT_NEXT(a_cfg_holds_input, aclk, aresetn, cfg_valid && cfg_ready, !s_ready,
                     "input taken while the matrix settles")
    `QVR_ASSERT_IMPLY(a_full_stall, aclk, aresetn, (&valid_reg) && !m_ready, !s_ready,
                      "input taken into a full stalled pipeline")
    `QVR_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, valid_reg[0],
                     "accepted transfer lost at the input stage")
    `QVR_ASSERT_NEXT(a_refill, aclk, aresetn,
                     m_valid && m_ready && valid_reg[NUM_STAGES-2], m_valid,
                     "output stage not refilled")

endmodule

`default_nettype wire

### tb/sv/qvr_rotation_checker.sv
// Checker for the quaternion vector rotation block: predicts each rotated vector and compares.
`timescale 1ns / 100ps

module qvr_rotation_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire qvr_pkg::vec_t                     s_vec_x,
    input  wire qvr_pkg::vec_t                     s_vec_y,
    input  wire qvr_pkg::vec_t                     s_vec_z,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire qvr_pkg::vec_t                     m_rot_x,
    input  wire qvr_pkg::vec_t                     m_rot_y,
    input  wire qvr_pkg::vec_t                     m_rot_z,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [qvr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire qvr_pkg::quat_t                    cfg_data,
    output int                                     failures,
    output int                                     results_due
);
    import qvr_pkg::*;

    // Keep the log readable when the block is badly broken.
    localparam int MAX_REPORTS = 40;

    // Wide enough for a full row sum: 38-bit coefficients times 32-bit components.
    typedef logic signed [127:0] wide_t;

    localparam wide_t ROUND_HALF = 128'sd2147483648;
    localparam wide_t ROT_MAX    = 128'sd2147483647;
    localparam wide_t ROT_MIN    = -128'sd2147483648;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
    } rot_vec_t;

    // Shadow copy of the quaternion registers.
    quat_t qw;
    quat_t qx;
    quat_t qy;
    quat_t qz;

    rot_vec_t rotations_due[$];
    int mismatches    = 0;
    int pending_count = 0;

    assign failures    = mismatches;
    assign results_due = pending_count;

    // One matrix row applied to the vector, rounded to Q16.16 with ties upward,
    // then clamped to the signed 32-bit range.
    function automatic vec_t round_row(input wide_t c0, c1, c2, input vec_t vx, vy, vz);
        wide_t acc;
        acc = c0 * vx + c1 * vy + c2 * vz;
        acc = (acc + ROUND_HALF) >>> 32;
        if (acc > ROT_MAX) begin
            acc = ROT_MAX;
        end else if (acc < ROT_MIN) begin
            acc = ROT_MIN;
        end
        return acc[31:0];
    endfunction

    // Vector part of q * (0, v) * conj(q) in its rotation matrix form, unnormalized.
    function automatic rot_vec_t rotate(input vec_t vx, vy, vz);
        wide_t w, x, y, z, ww, xx, yy, zz;
        rot_vec_t r;
        w  = qw;
        x  = qx;
        y  = qy;
        z  = qz;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        r.x = round_row(ww + xx - yy - zz, 2 * (x * y - w * z), 2 * (x * z + w * y),
                        vx, vy, vz);
        r.y = round_row(2 * (x * y + w * z), ww - xx + yy - zz, 2 * (y * z - w * x),
                        vx, vy, vz);
        r.z = round_row(2 * (x * z - w * y), 2 * (y * z + w * x), ww - xx - yy + zz,
                        vx, vy, vz);
        return r;
    endfunction

    task report_mismatch(input string field, input vec_t want, input vec_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endtask

    // Track configuration writes, queue a prediction per input transfer and
    // compare each output transfer with the oldest prediction.
    always @(posedge aclk) begin
        rot_vec_t want;
        if (!aresetn) begin
            qw = QUAT_W_RESET;
            qx = QUAT_V_RESET;
            qy = QUAT_V_RESET;
            qz = QUAT_V_RESET;
            rotations_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rotations_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("unexpected result: rot_x %0d, rot_y %0d, rot_z %0d",
                               m_rot_x, m_rot_y, m_rot_z);
                    end
                end else begin
                    want = rotations_due.pop_front();
                    if (m_rot_x !== want.x) report_mismatch("rot_x", want.x, m_rot_x);
                    if (m_rot_y !== want.y) report_mismatch("rot_y", want.y, m_rot_y);
                    if (m_rot_z !== want.z) report_mismatch("rot_z", want.z, m_rot_z);
                end
            end
            if (s_valid && s_ready) begin
                rotations_due.push_back(rotate(s_vec_x, s_vec_y, s_vec_z));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_QUAT_W: qw = cfg_data;
                    REG_QUAT_X: qx = cfg_data;
                    REG_QUAT_Y: qy = cfg_data;
                    REG_QUAT_Z: qz = cfg_data;
                endcase
            end
        end
        pending_count <= rotations_due.size();
    end

endmodule

### tb/sv/tb_quaternion_vector_rotation_top.sv
// Testbench top for the quaternion vector rotation block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotation_top;

    import qvr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int IDLE_HEAVY     = 68;
    localparam int IDLE_LIGHT     = 18;

    localparam vec_t  V_MAX   = 32'sh7fff_ffff;
    localparam vec_t  V_MIN   = 32'sh8000_0000;
    localparam vec_t  V_ONE   = 32'sd65536;
    localparam vec_t  V_HALF  = 32'sd32768;
    localparam quat_t Q_MAX   = 18'sh1ffff;
    localparam quat_t Q_MIN   = 18'sh20000;
    localparam quat_t Q_HALF  = 18'sd32768;
    localparam quat_t Q_COS45 = 18'sd46341;

    typedef enum int {
        PACE_FREE,
        PACE_SLOW_SOURCE,
        PACE_SLOW_SINK,
        PACE_BOTH
    } pace_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    vec_t                     s_vec_x;
    vec_t                     s_vec_y;
    vec_t                     s_vec_z;
    logic                     m_valid;
    logic                     m_ready;
    vec_t                     m_rot_x;
    vec_t                     m_rot_y;
    vec_t                     m_rot_z;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    quat_t                    cfg_data;

    int source_idle  = 0;
    int sink_stall   = 0;
    int hold_asks    = 0;
    int holds_done   = 0;
    int quiet_cycles = 0;
    int failures;
    int results_due;

    quaternion_vector_rotation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_vec_x   (s_vec_x),
        .s_vec_y   (s_vec_y),
        .s_vec_z   (s_vec_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rot_x   (m_rot_x),
        .m_rot_y   (m_rot_y),
        .m_rot_z   (m_rot_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qvr_rotation_checker rotation_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_vec_x     (s_vec_x),
        .s_vec_y     (s_vec_y),
        .s_vec_z     (s_vec_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rot_x     (m_rot_x),
        .m_rot_y     (m_rot_y),
        .m_rot_z     (m_rot_z),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .results_due (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off on request so the
    // pipeline fills and pushes back on the input.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // Watchdog: give up when no transfer happens on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FREE: begin
                source_idle = 0;
                sink_stall  = 0;
            end
            PACE_SLOW_SOURCE: begin
                source_idle = IDLE_HEAVY;
                sink_stall  = 0;
            end
            PACE_SLOW_SINK: begin
                source_idle = 0;
                sink_stall  = IDLE_HEAVY;
            end
            default: begin
                source_idle = IDLE_LIGHT;
                sink_stall  = IDLE_LIGHT;
            end
        endcase
    endtask

    // Offer one vector, after a random gap, and hold it until the transfer.
    task automatic send_vec(input vec_t x, input vec_t y, input vec_t z);
        while ($urandom_range(0, 99) < source_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_vec_x <= x;
        s_vec_y <= y;
        s_vec_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (NUM_STAGES + SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four quaternion registers back to back.
    task automatic set_quaternion(input quat_t w, input quat_t x, input quat_t y,
                                  input quat_t z);
        quat_t                   vals[4];
        logic [CFG_IDX_BITS-1:0] regs[4];
        vals = '{w, x, y, z};
        regs = '{REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random quaternion of roughly unit length, so results mostly stay in range.
    task automatic pick_unit_quat(output quat_t w, output quat_t x, output quat_t y,
                                  output quat_t z);
        real c[4];
        real norm;
        do begin
            for (int i = 0; i < 4; i++) begin
                c[i] = real'(int'($urandom_range(0, 131072)) - 65536);
            end
            norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        end while (norm < 1024.0);
        w = quat_t'($rtoi(c[0] * 65536.0 / norm));
        x = quat_t'($rtoi(c[1] * 65536.0 / norm));
        y = quat_t'($rtoi(c[2] * 65536.0 / norm));
        z = quat_t'($rtoi(c[3] * 65536.0 / norm));
    endtask

    // Vector component: extremes, full-range patterns and moderate values.
    function automatic vec_t pick_component();
        case ($urandom_range(0, 9))
            0: return V_MAX;
            1: return V_MIN;
            2, 3, 4, 5: return vec_t'($urandom);
            default: return vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    initial begin
        quat_t qa, qb, qc, qd;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_vec_x   = '0;
        s_vec_y   = '0;
        s_vec_z   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_QUAT_W;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: identity quaternion straight out of reset.
        set_pace(PACE_BOTH);
        send_vec(0, 0, 0);
        send_vec(V_MAX, V_MIN, V_ONE);
        send_vec(V_MIN, V_MAX, -1);
        send_vec(1, -V_ONE, V_HALF);

        // Half-scale quaternion puts exact ties on the rounding point.
        drain_results();
        set_quaternion(Q_HALF, 0, 0, 0);
        send_vec(2, -2, 3);

        // Quarter turn about z, slightly off unit length.
        drain_results();
        set_quaternion(Q_COS45, 0, 0, Q_COS45);
        send_vec(V_ONE, 0, 0);
        send_vec(-1, 1, V_MAX);

        // Most negative quaternion: large gain, saturation both ways.
        drain_results();
        set_quaternion(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_vec(V_MAX, V_MAX, V_MAX);
        send_vec(V_MIN, 0, V_MAX);
        send_vec(V_ONE, -V_ONE, 1);

        // Most positive quaternion.
        drain_results();
        set_quaternion(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vec(V_MIN, V_MIN, V_MIN);
        send_vec(1, 2, 3);
        send_vec(V_MAX, 0, 0);

        // Zero quaternion collapses every vector to zero.
        drain_results();
        set_quaternion(0, 0, 0, 0);
        send_vec(V_MAX, V_MIN, 12345);
        send_vec(V_MIN, V_MIN, V_MIN);

        // Mixed extremes.
        drain_results();
        set_quaternion(Q_MAX, Q_MIN, 0, Q_MAX);
        send_vec(V_MAX, V_MAX, V_MIN);

        // Random phases, each with its own quaternion; the four flow-control patterns take turns.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == 6) begin
                qa = quat_t'($urandom);
                qb = quat_t'($urandom);
                qc = quat_t'($urandom);
                qd = quat_t'($urandom);
            end else if (phase == 7) begin
                qa = quat_t'(int'($urandom_range(0, 4096)) - 2048);
                qb = quat_t'(int'($urandom_range(0, 4096)) - 2048);
                qc = quat_t'(int'($urandom_range(0, 4096)) - 2048);
                qd = quat_t'(int'($urandom_range(0, 4096)) - 2048);
            end else begin
                pick_unit_quat(qa, qb, qc, qd);
            end
            set_quaternion(qa, qb, qc, qd);
            set_pace(pace_t'(phase % 4));
            if (phase == 4) begin
                hold_asks++;
            end
            repeat (PHASE_ITEMS) send_vec(pick_component(), pick_component(), pick_component());
        end

        drain_results();
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
